>>> design/ltl_pkg.sv
// ----------------------------------------------------------------------------
// ltl_pkg
// shared types and constants of the lisp token lexer
// ----------------------------------------------------------------------------
package ltl_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_DOLLAR   = 4'd1,
        MODE_PIPE     = 4'd2,
        MODE_LINECOM  = 4'd3,
        MODE_HASH     = 4'd4,
        MODE_STRSTART = 4'd5,
        MODE_STR      = 4'd6,
        MODE_IDENT    = 4'd7,
        MODE_COMEMPTY = 4'd8,
        MODE_COMHELD  = 4'd9
    } mode_t;

    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_IDENT  = 4'd8;
    localparam logic [3:0] KIND_STRING = 4'd9;
    localparam logic [3:0] KIND_DOLLAR = 4'd5;
    localparam logic [3:0] KIND_DOLAT  = 4'd10;
    localparam logic [3:0] KIND_TEXT   = 4'd13;
    localparam logic [3:0] KIND_ERROR  = 4'd14;
    localparam logic [3:0] KIND_END    = 4'd15;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOL   = 8'h24;
    localparam logic [7:0] CH_LCURL = 8'h7b;
    localparam logic [7:0] CH_RCURL = 8'h7d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_UI    = 8'h49;

    localparam int RES_MAX = 4;

    // one result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  text_byte;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  indent;
        logic [11:0] length;
        logic        last;
    } res_t;

    // classified input character
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       ws;
        logic       digit;
        logic       single;
        logic [3:0] single_kind;
        logic       ident;
    } cls_t;

endpackage

>>> design/ltl_front.sv
// ----------------------------------------------------------------------------
// ltl_front
// input register stage: accepts characters and classifies them
// ----------------------------------------------------------------------------
module ltl_front import ltl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_ch,
    input  logic       s_end_of_text,
    input  logic       s_valid,
    output logic       s_ready,
    output cls_t       q_data,
    output logic       q_valid,
    input  logic       q_ready
);

    cls_t cls;
    cls_t data_reg;
    logic valid_reg;

    always_comb begin
        cls = '0;
        cls.ch    = s_ch;
        cls.eot   = s_end_of_text || (s_ch == 8'd0);
        cls.ws    = (s_ch == CH_SP) || (s_ch == CH_TAB) || (s_ch == CH_NL) || (s_ch == CH_CR);
        cls.digit = (s_ch >= 8'h30) && (s_ch <= 8'h39);
        cls.single = 1'b1;
        unique case (s_ch)
            8'h28:   cls.single_kind = 4'd0;
            8'h29:   cls.single_kind = 4'd1;
            8'h5b:   cls.single_kind = 4'd2;
            8'h5d:   cls.single_kind = 4'd3;
            8'h3a:   cls.single_kind = 4'd4;
            8'h27:   cls.single_kind = 4'd6;
            CH_LCURL: cls.single_kind = 4'd11;
            CH_RCURL: cls.single_kind = 4'd12;
            default: begin
                cls.single      = 1'b0;
                cls.single_kind = 4'd0;
            end
        endcase
        cls.ident = !cls.ws && !cls.single && (s_ch != CH_DOL);
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_data  = data_reg;
    assign q_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= cls;
        end
    end

endmodule

>>> design/ltl_back.sv
// ----------------------------------------------------------------------------
// ltl_back
// lexer state machine: turns one classified character into up to four results
// ----------------------------------------------------------------------------
module ltl_back import ltl_pkg::*; #(
    parameter int MAX_TOKEN_BYTES = 4095,
    parameter int MAX_NEST_DEPTH  = 255
) (
    input  logic aclk,
    input  logic aresetn,
    input  cls_t in_data,
    input  logic in_fire,
    output res_t res [RES_MAX],
    output logic [2:0] res_count
);

    localparam int NW = $clog2(MAX_NEST_DEPTH + 1);
    localparam int LW = $clog2(MAX_TOKEN_BYTES + 1);
    localparam logic [LW-1:0] TMAX = LW'(MAX_TOKEN_BYTES);
    localparam logic [NW-1:0] NMAX = NW'(MAX_NEST_DEPTH);

    mode_t       mode_reg, mode_next;
    logic [15:0] line_reg, line_next, col_reg, col_next, sl_reg, sl_next, sc_reg, sc_next;
    logic [7:0]  tab_reg, tab_next, held_reg, held_next, flags_reg, flags_next;
    logic [LW-1:0] len_reg, len_next;
    logic [NW-1:0] nest_reg, nest_next;

    res_t   r [RES_MAX];
    logic [2:0] n;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] f;
        logic [7:0] h;
        logic       feed_ident;
        logic       push_pipe;
        logic       finish_id;
        logic       dispatch;
        logic       num;
        c = in_data.ch;
        mode_next = mode_reg;
        line_next = line_reg; col_next = col_reg; tab_next = tab_reg;
        held_next = held_reg; flags_next = flags_reg; len_next = len_reg;
        sl_next = sl_reg; sc_next = sc_reg; nest_next = nest_reg;
        n = 3'd0;
        for (int i = 0; i < RES_MAX; i++) r[i] = '0;
        feed_ident = 1'b0; push_pipe = 1'b0; finish_id = 1'b0; dispatch = 1'b0;
        f = 8'd0; h = held_reg; num = 1'b0;

        if (in_data.eot) begin
            unique case (mode_reg)
                MODE_DOLLAR: begin
                    r[n[1:0]] = '{KIND_DOLLAR, 8'd0, line_reg, col_reg, tab_reg, 12'd0, 1'b0};
                    n = n + 3'd1;
                    col_next = sat_add(col_reg, 2'd1);
                end
                MODE_PIPE: begin
                    r[n[1:0]] = '{KIND_TEXT, CH_PIPE, 16'd0, 16'd0, 8'd0, 12'd0, 1'b0};
                    n = n + 3'd1;
                    col_next = sat_add(col_reg, 2'd1);
                    r[n[1:0]] = '{KIND_IDENT, 8'd0, line_reg, col_next, tab_reg, 12'd1, 1'b0};
                    n = n + 3'd1;
                end
                MODE_IDENT: begin
                    f = flags_reg;
                    num = f[0] || (f[1] && len_reg > LW'(1) && !f[2] && !f[4]);
                    r[n[1:0]] = '{num ? KIND_NUMBER : KIND_IDENT, 8'd0, line_reg, col_reg,
                                  tab_reg, 12'(len_reg), 1'b0};
                    n = n + 3'd1;
                end
                MODE_LINECOM: begin
                    line_next = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
                    col_next = 16'd0; tab_next = 8'd0;
                end
                MODE_COMHELD: begin
                    if (held_reg == CH_NL) begin
                        line_next = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
                        col_next = 16'd1; tab_next = 8'd0;
                    end else begin
                        if (held_reg == CH_TAB && tab_reg != 8'hff) tab_next = tab_reg + 8'd1;
                        col_next = sat_add(col_reg, 2'd1);
                    end
                    r[n[1:0]] = '{KIND_ERROR, 8'd0, line_next, col_next, tab_next, 12'd0, 1'b0};
                    n = n + 3'd1;
                end
                MODE_COMEMPTY, MODE_STRSTART, MODE_STR: begin
                    r[n[1:0]] = '{KIND_ERROR, 8'd0, line_reg, col_reg, tab_reg, 12'd0, 1'b0};
                    n = n + 3'd1;
                end
                default: ;
            endcase
            r[n[1:0]] = '{KIND_END, 8'd0, line_next, col_next, tab_next, 12'd0, 1'b0};
            n = n + 3'd1;
            mode_next = MODE_IDLE;
            line_next = '0; col_next = '0; tab_next = '0; nest_next = '0;
            flags_next = '0; len_next = '0; sl_next = '0; sc_next = '0; held_next = '0;
        end else begin
            unique case (mode_reg)
                MODE_DOLLAR: begin
                    if (c == CH_AT) begin
                        r[n[1:0]] = '{KIND_DOLAT, 8'd0, line_reg, col_reg, tab_reg, 12'd0,
                                      1'b0};
                        n = n + 3'd1;
                        col_next = sat_add(col_reg, 2'd2);
                        mode_next = MODE_IDLE;
                    end else begin
                        r[n[1:0]] = '{KIND_DOLLAR, 8'd0, line_reg, col_reg, tab_reg, 12'd0,
                                      1'b0};
                        n = n + 3'd1;
                        col_next = sat_add(col_reg, 2'd1);
                        dispatch = 1'b1;
                    end
                end
                MODE_PIPE: begin
                    if (c == CH_LCURL) begin
                        col_next = sat_add(col_reg, 2'd2);
                        nest_next = NW'(1);
                        mode_next = MODE_COMEMPTY;
                    end else begin
                        push_pipe = 1'b1;
                    end
                end
                MODE_LINECOM: begin
                    if (c == CH_NL) begin
                        line_next = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
                        col_next = 16'd0; tab_next = 8'd0;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HASH: begin
                    if (in_data.ident) col_next = sat_add(col_reg, 2'd1);
                    else dispatch = 1'b1;
                end
                MODE_STRSTART: begin
                    col_next = sat_add(col_reg, 2'd1);
                    sl_next = line_reg; sc_next = col_next;
                    if (c == CH_QUOTE) begin
                        r[n[1:0]] = '{KIND_STRING, 8'd0, line_reg, col_next, tab_reg, 12'd0,
                                      1'b0};
                        n = n + 3'd1;
                        len_next = '0;
                        mode_next = MODE_IDLE;
                    end else begin
                        r[n[1:0]] = '{KIND_TEXT, c, 16'd0, 16'd0, 8'd0, 12'd0, 1'b0};
                        n = n + 3'd1;
                        len_next = LW'(1); held_next = c; mode_next = MODE_STR;
                    end
                end
                MODE_STR: begin
                    if (c == CH_NL) begin
                        line_next = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
                        col_next = 16'd0; tab_next = 8'd0;
                    end else begin
                        col_next = sat_add(col_reg, 2'd1);
                    end
                    if (c == CH_QUOTE && held_reg != CH_BSL) begin
                        r[n[1:0]] = '{KIND_STRING, 8'd0, sl_reg, sc_reg, tab_next,
                                      12'(len_reg), 1'b0};
                        n = n + 3'd1;
                        len_next = '0; held_next = 8'd0; mode_next = MODE_IDLE;
                    end else begin
                        r[n[1:0]] = '{KIND_TEXT, c, 16'd0, 16'd0, 8'd0, 12'd0, 1'b0};
                        n = n + 3'd1;
                        if (len_reg < TMAX) len_next = len_reg + LW'(1);
                        held_next = c;
                    end
                end
                MODE_IDENT: begin
                    if (in_data.ident) feed_ident = 1'b1;
                    else begin
                        finish_id = 1'b1;
                        dispatch = 1'b1;
                    end
                end
                MODE_COMEMPTY: begin
                    held_next = c;
                    mode_next = MODE_COMHELD;
                end
                MODE_COMHELD: begin
                    if (h == CH_RCURL && c == CH_PIPE) begin
                        if (nest_reg != '0) nest_next = nest_reg - NW'(1);
                        col_next = sat_add(col_reg, 2'd1);
                    end else if (h == CH_PIPE && c == CH_LCURL) begin
                        if (nest_reg < NMAX) nest_next = nest_reg + NW'(1);
                        col_next = sat_add(col_reg, 2'd1);
                    end else if (h == CH_NL) begin
                        line_next = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
                        col_next = 16'd1; tab_next = 8'd0;
                    end else begin
                        if (h == CH_TAB && tab_reg != 8'hff) tab_next = tab_reg + 8'd1;
                        col_next = sat_add(col_reg, 2'd1);
                    end
                    if (nest_next == '0) begin
                        held_next = 8'd0; mode_next = MODE_IDLE;
                    end else begin
                        held_next = c;
                    end
                end
                default: dispatch = 1'b1;
            endcase

            // a lone pipe becomes the first identifier byte
            if (push_pipe) begin
                r[n[1:0]] = '{KIND_TEXT, CH_PIPE, 16'd0, 16'd0, 8'd0, 12'd0, 1'b0};
                n = n + 3'd1;
                flags_next = 8'd0;
                len_next = LW'(1);
                col_next = sat_add(col_reg, 2'd1);
                mode_next = MODE_IDENT;
                if (in_data.ident) feed_ident = 1'b1;
                else begin
                    finish_id = 1'b1;
                    dispatch = 1'b1;
                end
            end

            if (finish_id) begin
                f = flags_next;
                num = f[0] || (f[1] && len_next > LW'(1) && !f[2] && !f[4]);
                r[n[1:0]] = '{num ? KIND_NUMBER : KIND_IDENT, 8'd0, line_next, col_next,
                              tab_next, 12'(len_next), 1'b0};
                n = n + 3'd1;
                len_next = '0; flags_next = 8'd0; mode_next = MODE_IDLE;
            end

            if (dispatch) begin
                mode_next = MODE_IDLE;
                if (in_data.ws) begin
                    if (c == CH_NL) begin
                        line_next = (line_next != 16'hffff) ? line_next + 16'd1 : line_next;
                        col_next = 16'd0; tab_next = 8'd0;
                    end else begin
                        if (c == CH_TAB && tab_next != 8'hff) tab_next = tab_next + 8'd1;
                        col_next = sat_add(col_next, 2'd1);
                    end
                end else if (in_data.single) begin
                    r[n[1:0]] = '{in_data.single_kind, 8'd0, line_next, col_next, tab_next,
                                  12'd0, 1'b0};
                    n = n + 3'd1;
                    col_next = sat_add(col_next, 2'd1);
                end else if (c == CH_DOL) mode_next = MODE_DOLLAR;
                else if (c == CH_PIPE) mode_next = MODE_PIPE;
                else if (c == CH_SEMI) mode_next = MODE_LINECOM;
                else if (c == CH_HASH) mode_next = MODE_HASH;
                else if (c == CH_QUOTE) mode_next = MODE_STRSTART;
                else begin
                    len_next = '0; flags_next = 8'd0;
                    feed_ident = 1'b1;
                    mode_next = MODE_IDENT;
                end
            end

            // incremental number rule for one identifier byte
            if (feed_ident) begin
                f = flags_next;
                if (len_next == '0) begin
                    if (in_data.digit) f = 8'h01;
                    else if (c == CH_PLUS || c == CH_MINUS) f = 8'h02;
                    else if (c == CH_DOT) f = 8'h42;
                    else f = 8'h00;
                end else if (f[1] && !f[2]) begin
                    if (f[5]) f[2] = 1'b1;
                    f[4] = 1'b0; f[5] = 1'b0;
                    if (c == CH_E) begin
                        if (len_next == LW'(1) || f[3]) f[2] = 1'b1;
                        else begin
                            f[3] = 1'b1; f[4] = 1'b1;
                        end
                    end else if (c == CH_DOT) begin
                        if (f[6]) f[2] = 1'b1;
                    end else if (c == CH_LI || c == CH_UI) begin
                        f[5] = 1'b1;
                    end else if (!in_data.digit) begin
                        f[2] = 1'b1;
                    end
                end
                flags_next = f;
                r[n[1:0]] = '{KIND_TEXT, c, 16'd0, 16'd0, 8'd0, 12'd0, 1'b0};
                n = n + 3'd1;
                if (len_next < TMAX) len_next = len_next + LW'(1);
                col_next = sat_add(col_next, 2'd1);
                mode_next = MODE_IDENT;
            end
        end
        if (n != 3'd0) r[2'(n - 3'd1)].last = 1'b1;
    end

    assign res = r;
    assign res_count = in_fire ? n : 3'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            line_reg <= '0; col_reg <= '0; tab_reg <= '0; nest_reg <= '0;
            flags_reg <= '0; len_reg <= '0; sl_reg <= '0; sc_reg <= '0; held_reg <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            line_reg <= line_next; col_reg <= col_next; tab_reg <= tab_next;
            nest_reg <= nest_next; flags_reg <= flags_next; len_reg <= len_next;
            sl_reg <= sl_next; sc_reg <= sc_next; held_reg <= held_next;
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= TMAX) else $error("token length beyond limit");
    a_eot_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_data.eot |=> mode_reg == MODE_IDLE && line_reg == 16'd0)
        else $error("end of text did not clear state");
    a_res_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_data.eot |-> res_count != 3'd0) else $error("no end result");

endmodule

>>> design/ltl_queue.sv
// ----------------------------------------------------------------------------
// ltl_queue
// result queue: takes up to four results a cycle; while rd_ready is high, sends one a cycle
// ----------------------------------------------------------------------------
module ltl_queue import ltl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  res_t       wr_data [RES_MAX],
    input  logic [2:0] wr_count,
    output logic       room,
    output res_t       rd_data,
    output logic       rd_valid,
    input  logic       rd_ready
);

    localparam int DEPTH = 8;

    res_t       mem [DEPTH];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic       pop;

    assign rd_valid = cnt_reg != 4'd0;
    assign rd_data  = mem[rp_reg];
    assign pop      = rd_valid && rd_ready;
    assign room     = cnt_reg <= 4'd4;
    assign cnt_next = cnt_reg + 4'(wr_count) - 4'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RES_MAX; i++) begin
            if (3'(i) < wr_count) mem[wp_reg + 3'(i)] <= wr_data[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + wr_count;
            rp_reg  <= rp_reg + 3'(pop);
            cnt_reg <= cnt_next;
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'(DEPTH)) else $error("result queue overflow");
    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_count != 3'd0 |-> room) else $error("write without room");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_count == 3'd0 && pop |=> cnt_reg == $past(cnt_reg) - 4'd1)
        else $error("count step wrong");

endmodule

>>> design/lisp_token_lexer.sv
// ----------------------------------------------------------------------------
// lisp_token_lexer
// streaming lexer for a small lisp dialect, one source byte per beat
// ----------------------------------------------------------------------------
// s_ channel: one source byte (s_ch) or an end mark (s_end_of_text) per beat.
// m_ channel: result beats (tokens, text bytes, errors, end), m_last marks
// the final result caused by one input beat.
// a byte enters the input register, the lexer state machine handles it
// combinationally and writes its zero to four results into an eight-entry queue.
// a result passes the input register and the queue before it reaches the output.
// throughput: one byte per cycle while the result queue has room for four;
// the output drains one result per cycle while m_ready is high, so bytes making
// several results slow the input to the drain rate of the queue.
// reset clears all lexer state to idle at line and column zero and empties
// the queue. a stalled receiver fills the queue, then input ready drops.
// ----------------------------------------------------------------------------
module lisp_token_lexer import ltl_pkg::*; #(
    parameter int MAX_TOKEN_BYTES = 4095,
    parameter int MAX_NEST_DEPTH  = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_text,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [3:0]  m_kind,
    output logic [7:0]  m_text_byte,
    output logic [15:0] m_line,
    output logic [15:0] m_column,
    output logic [7:0]  m_indent,
    output logic [11:0] m_length,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);

    cls_t       q_data;
    logic       q_valid, room, fire;
    res_t       res [RES_MAX];
    res_t       out;
    logic [2:0] res_count;

    assign fire = q_valid && room;

    ltl_front u_front (
        .aclk, .aresetn, .s_ch, .s_end_of_text, .s_valid, .s_ready,
        .q_data, .q_valid, .q_ready(room)
    );

    ltl_back #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES), .MAX_NEST_DEPTH(MAX_NEST_DEPTH)) u_back (
        .aclk, .aresetn, .in_data(q_data), .in_fire(fire), .res, .res_count
    );

    ltl_queue u_queue (
        .aclk, .aresetn, .wr_data(res), .wr_count(res_count), .room,
        .rd_data(out), .rd_valid(m_valid), .rd_ready(m_ready)
    );

    assign m_kind      = out.kind;
    assign m_text_byte = out.text_byte;
    assign m_line      = out.line;
    assign m_column    = out.column;
    assign m_indent    = out.indent;
    assign m_length    = out.length;
    assign m_last      = out.last;

endmodule
